[rtl/g2dp_pkg.sv]
// Shared types and constants for the 2D Gaussian potential pipeline.
// Holds the base-2 exponent table, built at elaboration time by an integer series.
// No dependencies.
package g2dp_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_PEAK_HEIGHT = 3'd0;
  localparam logic [2:0] REG_CENTER_X    = 3'd1;
  localparam logic [2:0] REG_CENTER_Y    = 3'd2;
  localparam logic [2:0] REG_COEF_X      = 3'd3;
  localparam logic [2:0] REG_COEF_Y      = 3'd4;

  localparam int EXP_TABLE_DEPTH = 64;
  localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int ROM_W  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PROD_W = 16 + IDX_W;

  localparam int E16_W = 20;  // exponent below saturation, Q.16
  localparam int T_W   = 21;  // base-2 exponent, Q.16
  localparam int N_W   = 5;   // integer part of the base-2 exponent
  localparam int M_W   = 17;  // mantissa, Q.16, at most 1.0

  localparam logic [15:0] LOG2E_Q15 = 16'd47274;
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam int SERIES_TERMS = 20;

  typedef logic [M_W-1:0] exp_rom_t [0:EXP_TABLE_DEPTH];

  typedef struct packed {
    logic             last;
    logic             sat;
    logic [E16_W-1:0] e16;
  } exp_req_t;

  typedef struct packed {
    logic           last;
    logic           sat;
    logic [N_W-1:0] n;
    logic [M_W-1:0] m;
  } exp_rsp_t;

  // Unsigned long division by shift and subtract, quotient truncated
  function automatic longint unsigned udiv_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(exp(-z) * 2^16) for z in Q.30 by a truncated Taylor series
  function automatic logic [M_W-1:0] exp_neg_q16(longint unsigned z);
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned term;
    longint unsigned res;
    pos  = 64'd1 << 30;
    neg  = 64'd0;
    term = 64'd1 << 30;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = udiv_u64((term * z) >> 30, 64'(n));
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    res = ((pos - neg) + (64'd1 << 13)) >> 14;
    return res[M_W-1:0];
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t        rom;
    longint unsigned z;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      z = (longint'(k) * LN2_Q30) / EXP_TABLE_DEPTH;
      rom[k] = exp_neg_q16(z);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[rtl/g2dp_exp2.sv]
// Four-stage evaluator of 2^-t: log2(e) scaling, table lookup and linear interpolation.
// Depends on g2dp_pkg for the exponent table and the request/response structs.
module g2dp_exp2
  import g2dp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  exp_req_t in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output exp_rsp_t out_rsp
);

  // Stage A: base-2 exponent t = e16 * log2(e)
  logic           vld_a, rdy_a;
  logic [T_W-1:0] t_a;
  logic           sat_a, last_a;
  // Stage B: table lookup
  logic           vld_b, rdy_b;
  logic [M_W-1:0] hi_b, diff_b;
  logic [15:0]    r_b;
  logic [N_W-1:0] n_b;
  logic           sat_b, last_b;
  // Stage C: slope times fraction
  logic           vld_c, rdy_c;
  logic [M_W-1:0] hi_c;
  logic [M_W+15:0] dr_c;
  logic [N_W-1:0] n_c;
  logic           sat_c, last_c;
  // Stage D: interpolated mantissa
  logic           vld_d, rdy_d;
  exp_rsp_t       rsp_d;

  logic [35:0]       t_full;
  logic [PROD_W-1:0] p_b;
  logic [IDX_W-1:0]  i_b;
  logic [ROM_W-1:0]  idx0, idx1;
  logic [M_W-1:0]    rom_lo;
  logic [M_W-1:0]    rom_hi;

  assign rdy_d    = !vld_d || out_ready;
  assign rdy_c    = !vld_c || rdy_d;
  assign rdy_b    = !vld_b || rdy_c;
  assign rdy_a    = !vld_a || rdy_b;
  assign in_ready = rdy_a;

  assign t_full = 36'(in_req.e16) * 36'(LOG2E_Q15);

  assign p_b    = PROD_W'(t_a[15:0]) * PROD_W'(EXP_TABLE_DEPTH);
  assign i_b    = p_b[PROD_W-1:16];
  assign idx0   = ROM_W'(i_b);
  assign idx1   = idx0 + ROM_W'(1);
  assign rom_hi = EXP_ROM[idx0];
  assign rom_lo = EXP_ROM[idx1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else begin
      if (rdy_a) vld_a <= in_valid;
      if (rdy_b) vld_b <= vld_a;
      if (rdy_c) vld_c <= vld_b;
      if (rdy_d) vld_d <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      t_a    <= t_full[35:15];
      sat_a  <= in_req.sat;
      last_a <= in_req.last;
    end
    if (rdy_b && vld_a) begin
      hi_b   <= rom_hi;
      diff_b <= rom_hi - rom_lo;
      r_b    <= p_b[15:0];
      n_b    <= t_a[T_W-1:16];
      sat_b  <= sat_a;
      last_b <= last_a;
    end
    if (rdy_c && vld_b) begin
      hi_c   <= hi_b;
      dr_c   <= (M_W+16)'(diff_b) * (M_W+16)'(r_b);
      n_c    <= n_b;
      sat_c  <= sat_b;
      last_c <= last_b;
    end
    if (rdy_d && vld_c) begin
      rsp_d.m    <= hi_c - dr_c[M_W+15:16];
      rsp_d.n    <= n_c;
      rsp_d.sat  <= sat_c;
      rsp_d.last <= last_c;
    end
  end

  assign out_valid = vld_d;
  assign out_rsp   = rsp_d;

endmodule

[rtl/gaussian_2d_potential_unit.sv]
// Top level of the 2D Gaussian potential unit: offsets, squares, coefficient products,
// exponent sum, then the g2dp_exp2 evaluator and the peak-height scaling.
// Depends on g2dp_pkg and g2dp_exp2.
//
// Usage:
//   Input stream (s_*) carries one grid point per request: point_x in s_tdata[15:0],
//   point_y in s_tdata[31:16], both signed Q5.10, and the grid's last marker on s_tlast.
//   Output stream (m_*) returns the potential in m_tdata[15:0] with the marker on m_tlast.
//   Registers are written through cfg_we / cfg_index / cfg_data while no point is in flight:
//   0 peak height, 1 center x, 2 center y, 3 coef x, 4 coef y. Other indexes are ignored.
// Stages and throughput:
//   Ten register stages; one point per cycle is sustained while m_tready stays high.
//   Each multiplier in the chain (square, coefficient, log2(e), slope, peak height) is
//   followed by a register.
// Reset:
//   rst clears all stage valids and the configuration registers to zero.
// Backpressure:
//   Every stage holds its contents while the next cannot take them; a stalled m_tready lets the
//   pipe fill its empty stages, then s_tready drops. Nothing is lost or repeated.
module gaussian_2d_potential_unit
  import g2dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // point_x [15:0], point_y [31:16]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // potential [15:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] peak_height;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] coef_x;
  logic [15:0] coef_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_height <= '0;
      center_x    <= '0;
      center_y    <= '0;
      coef_x      <= '0;
      coef_y      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEAK_HEIGHT: peak_height <= cfg_data;
        REG_CENTER_X:    center_x    <= cfg_data;
        REG_CENTER_Y:    center_y    <= cfg_data;
        REG_COEF_X:      coef_x      <= cfg_data;
        REG_COEF_Y:      coef_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        vld1, rdy1;
  logic [15:0] ax1, ay1;
  logic        last1;
  logic        vld2, rdy2;
  logic [31:0] sqx2, sqy2;
  logic        last2;
  logic        vld3, rdy3;
  logic [47:0] px3, py3;
  logic        last3;
  logic        vld4, rdy4;
  exp_req_t    req4;
  logic        exp_in_ready;
  logic        exp_vld;
  exp_rsp_t    exp_rsp;
  logic        vld8, rdy8;
  logic [M_W+15:0] prod8;
  logic [N_W-1:0]  n8;
  logic        sat8, last8;
  logic        vld9, rdy9;
  logic [15:0] pot9;
  logic        last9;

  logic signed [16:0] dx, dy;
  logic [16:0]        dx_mag, dy_mag;
  logic [48:0]        e28;
  logic [5:0]         shamt;
  logic [M_W+15:0]    scaled;

  assign rdy9     = !vld9 || m_tready;
  assign rdy8     = !vld8 || rdy9;
  assign rdy4     = !vld4 || exp_in_ready;
  assign rdy3     = !vld3 || rdy4;
  assign rdy2     = !vld2 || rdy3;
  assign rdy1     = !vld1 || rdy2;
  assign s_tready = rdy1;

  // |point - center| fits in 16 bits unsigned
  assign dx     = signed'({s_tdata[15], s_tdata[15:0]}) - signed'({center_x[15], center_x});
  assign dy     = signed'({s_tdata[31], s_tdata[31:16]}) - signed'({center_y[15], center_y});
  assign dx_mag = dx[16] ? 17'(-dx) : 17'(dx);
  assign dy_mag = dy[16] ? 17'(-dy) : 17'(dy);

  assign e28 = {1'b0, px3} + {1'b0, py3};

  assign shamt  = 6'd16 + 6'(n8);
  assign scaled = prod8 >> shamt;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld8 <= 1'b0;
      vld9 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= s_tvalid;
      if (rdy2) vld2 <= vld1;
      if (rdy3) vld3 <= vld2;
      if (rdy4) vld4 <= vld3;
      if (rdy8) vld8 <= exp_vld;
      if (rdy9) vld9 <= vld8;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      ax1   <= dx_mag[15:0];
      ay1   <= dy_mag[15:0];
      last1 <= s_tlast;
    end
    if (rdy2 && vld1) begin
      sqx2  <= 32'(ax1) * 32'(ax1);
      sqy2  <= 32'(ay1) * 32'(ay1);
      last2 <= last1;
    end
    if (rdy3 && vld2) begin
      px3   <= 48'(sqx2) * 48'(coef_x);
      py3   <= 48'(sqy2) * 48'(coef_y);
      last3 <= last2;
    end
    // Saturate once the Q.16 exponent reaches 16
    if (rdy4 && vld3) begin
      req4.e16  <= e28[E16_W+11:12];
      req4.sat  <= |e28[48:E16_W+12];
      req4.last <= last3;
    end
    if (rdy8 && exp_vld) begin
      prod8 <= (M_W+16)'(peak_height) * (M_W+16)'(exp_rsp.m);
      n8    <= exp_rsp.n;
      sat8  <= exp_rsp.sat;
      last8 <= exp_rsp.last;
    end
    if (rdy9 && vld8) begin
      pot9  <= sat8 ? 16'd0 : scaled[15:0];
      last9 <= last8;
    end
  end

  g2dp_exp2 u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld4),
    .in_ready  (exp_in_ready),
    .in_req    (req4),
    .out_valid (exp_vld),
    .out_ready (rdy8),
    .out_rsp   (exp_rsp)
  );

  assign m_tvalid = vld9;
  assign m_tdata  = pot9;
  assign m_tlast  = last9;

`ifndef SYNTHESIS
  a_reset_empties_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_exp_req_held: assert property (@(posedge clk) disable iff (rst)
    vld4 && !rdy4 |=> vld4 && $stable(req4))
    else $error("exponent request changed while stalled");

  a_exp_rsp_held: assert property (@(posedge clk) disable iff (rst)
    exp_vld && !rdy8 |=> exp_vld && $stable(exp_rsp))
    else $error("exponent response changed while stalled");

  a_mantissa_range: assert property (@(posedge clk) disable iff (rst)
    exp_vld && !exp_rsp.sat |-> exp_rsp.m <= 17'd65536)
    else $error("interpolated mantissa above one");
`endif

endmodule

[tb/potential_checker.sv]
`timescale 1ns / 100ps
// Result checker for gaussian_2d_potential_unit: tracks register writes, predicts each
// point's potential in its own fixed-point model and compares every returned result.
// Depends on g2dp_pkg for register indexes and table constants.
module potential_checker
  import g2dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // point_x [15:0], point_y [31:16]
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // potential [15:0]
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [15:0] potential;
    logic        last;
  } potential_exp_t;

  potential_exp_t  expected_q [$];
  longint unsigned exp2_frac_tbl [0:EXP_TABLE_DEPTH];
  logic [15:0]     peak;
  logic [15:0]     ctr_x;
  logic [15:0]     ctr_y;
  logic [15:0]     kx;
  logic [15:0]     ky;
  int              err_cnt = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // round(exp(-z) * 2^16), z in Q.30, by a truncated series summed in Q.30
  function automatic longint unsigned neg_exp_q16(longint unsigned z);
    longint unsigned plus_sum;
    longint unsigned minus_sum;
    longint unsigned term;
    plus_sum  = 64'd1 << 30;
    minus_sum = 64'd0;
    term      = 64'd1 << 30;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * z) >> 30) / 64'(k);
      if (k % 2 == 1) begin
        minus_sum = minus_sum + term;
      end else begin
        plus_sum = plus_sum + term;
      end
    end
    return ((plus_sum - minus_sum) + (64'd1 << 13)) >> 14;
  endfunction

  initial begin
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      exp2_frac_tbl[k] = neg_exp_q16((64'(k) * LN2_Q30) / 64'(EXP_TABLE_DEPTH));
    end
  end

  function automatic logic [15:0] gaussian_at(logic [15:0] px, logic [15:0] py);
    logic [16:0]     dx;
    logic [16:0]     dy;
    logic [16:0]     mag_x;
    logic [16:0]     mag_y;
    longint unsigned e28;
    longint unsigned e16;
    longint unsigned t;
    longint unsigned n;
    longint unsigned f;
    longint unsigned p;
    longint unsigned idx;
    longint unsigned r;
    longint unsigned m;
    longint unsigned pot;
    dx = {px[15], px} - {ctr_x[15], ctr_x};
    dy = {py[15], py} - {ctr_y[15], ctr_y};
    mag_x = dx[16] ? (~dx + 17'd1) : dx;
    mag_y = dy[16] ? (~dy + 17'd1) : dy;
    e28 = 64'(mag_x) * 64'(mag_x) * 64'(kx) + 64'(mag_y) * 64'(mag_y) * 64'(ky);
    e16 = e28 >> 12;
    // saturated exponent gives zero
    if (e16 >= (64'd16 << 16)) begin
      return 16'd0;
    end
    t   = (e16 * 64'(LOG2E_Q15)) >> 15;
    n   = t >> 16;
    f   = t & 64'hffff;
    p   = f * 64'(EXP_TABLE_DEPTH);
    idx = p >> 16;
    r   = p & 64'hffff;
    if (idx >= 64'(EXP_TABLE_DEPTH)) begin
      idx = 64'(EXP_TABLE_DEPTH) - 1;
    end
    m = exp2_frac_tbl[idx]
      - (((exp2_frac_tbl[idx] - exp2_frac_tbl[idx + 1]) * r) >> 16);
    pot = (64'(peak) * m) >> (16 + n);
    return 16'(pot);
  endfunction

  always @(posedge clk) begin
    potential_exp_t head;
    potential_exp_t fresh;
    if (rst) begin
      expected_q.delete();
      peak  = 16'd0;
      ctr_x = 16'd0;
      ctr_y = 16'd0;
      kx    = 16'd0;
      ky    = 16'd0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          $error("result with no pending request: potential %0d last %0d", m_tdata, m_tlast);
        end else begin
          head = expected_q.pop_front();
          if (m_tdata !== head.potential) begin
            err_cnt++;
            $error("potential expected %0d actual %0d", head.potential, m_tdata);
          end
          if (m_tlast !== head.last) begin
            err_cnt++;
            $error("last_out expected %0d actual %0d", head.last, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        fresh.potential = gaussian_at(s_tdata[15:0], s_tdata[31:16]);
        fresh.last      = s_tlast;
        expected_q.push_back(fresh);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PEAK_HEIGHT: peak  = cfg_data;
          REG_CENTER_X:    ctr_x = cfg_data;
          REG_CENTER_Y:    ctr_y = cfg_data;
          REG_COEF_X:      kx    = cfg_data;
          REG_COEF_Y:      ky    = cfg_data;
          default: ;
        endcase
      end
    end
    pending    <= expected_q.size();
    mismatches <= err_cnt;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Top of the gaussian_2d_potential_unit testbench: clock, reset, register settings,
// directed and random grid points, random idling, watchdog and verdict.
// Depends on g2dp_pkg, gaussian_2d_potential_unit and potential_checker.
module tb;
  import g2dp_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_POINTS = 200;
  localparam int RANDOM_PHASES = 8;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = 32'd0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_PEAK_HEIGHT;
  logic [15:0] cfg_data  = 16'd0;
  int          mismatches;
  int          pending;
  int          gap_pct   = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  gaussian_2d_potential_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  potential_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [15:0] rand_scaled();
    return 16'($urandom_range(0, 65535) >> $urandom_range(0, 16));
  endfunction

  function automatic logic [15:0] signed_offset();
    logic [15:0] mag;
    mag = rand_scaled();
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // present one request and hold it until taken; valid stays high for the next one
  task automatic send_point(input logic [15:0] px, input logic [15:0] py, input logic last);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {py, px};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drain the pipe before touching registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_setting(input logic [15:0] v_peak, input logic [15:0] v_cx,
                              input logic [15:0] v_cy, input logic [15:0] v_kx,
                              input logic [15:0] v_ky);
    logic [2:0] junk;
    junk = REG_COEF_Y + 3'(1 + $urandom_range(0, 2));
    wait_idle();
    for (int k = 0; k < 6; k++) begin
      cfg_we <= 1'b1;
      case (k)
        0: begin cfg_index <= REG_PEAK_HEIGHT; cfg_data <= v_peak; end
        1: begin cfg_index <= REG_CENTER_X;    cfg_data <= v_cx;   end
        2: begin cfg_index <= REG_CENTER_Y;    cfg_data <= v_cy;   end
        3: begin cfg_index <= REG_COEF_X;      cfg_data <= v_kx;   end
        4: begin cfg_index <= REG_COEF_Y;      cfg_data <= v_ky;   end
        default: begin cfg_index <= junk;      cfg_data <= 16'($urandom); end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] v_peak;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] sx;
    logic [15:0] sy;
    int          sent;
    int          w;
    int          h;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings scale everything to zero
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'h8000, 16'h7fff, 1'b1);

    load_setting(16'hffff, 16'h0000, 16'h0000, 16'h0100, 16'h0100);
    send_point(16'h0000, 16'h0000, 1'b0);   // zero exponent
    send_point(16'h7fff, 16'h8000, 1'b0);   // saturated
    send_point(16'h0400, 16'h0000, 1'b0);
    send_point(16'h0000, 16'hfc00, 1'b0);
    send_point(16'h0200, 16'h0200, 1'b0);
    send_point(16'h0001, 16'hffff, 1'b0);
    send_point(16'h8000, 16'h8000, 1'b1);

    load_setting(16'hffff, 16'h8000, 16'h7fff, 16'hffff, 16'hffff);
    send_point(16'h8000, 16'h7fff, 1'b0);
    send_point(16'h7fff, 16'h8000, 1'b0);
    send_point(16'h8001, 16'h7fff, 1'b0);
    send_point(16'h8010, 16'h7fef, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);

    load_setting(16'h8001, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    send_point(16'h7fff, 16'h8000, 1'b0);
    send_point(16'h8000, 16'h7fff, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);

    // edge of saturation on x alone: |dx| = 4096 is the first saturated offset
    load_setting(16'hffff, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_point(16'h0fff, 16'h1234, 1'b0);
    send_point(16'h1000, 16'h0000, 1'b0);
    send_point(16'hf000, 16'h0000, 1'b0);
    send_point(16'hf001, 16'h7fff, 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      v_peak = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      cx = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff)
                                       : 16'($urandom);
      cy = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff)
                                       : 16'($urandom);
      load_setting(v_peak, cx, cy,
                   ($urandom_range(0, 5) == 0) ? 16'hffff : rand_scaled(),
                   ($urandom_range(0, 5) == 0) ? 16'hffff : rand_scaled());
      if (ph == 3 || ph == RANDOM_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 5 + $urandom_range(0, 25);
        stall_pct = 5 + $urandom_range(0, 25);
      end
      sent = 0;
      while (sent < PHASE_POINTS) begin
        if ($urandom_range(0, 9) < 7) begin
          // grid scan near the center, last on its final point
          w  = $urandom_range(1, 8);
          h  = $urandom_range(1, 8);
          x0 = cx + signed_offset();
          y0 = cy + signed_offset();
          sx = 16'($urandom_range(1, 64)) << $urandom_range(0, 6);
          sy = 16'($urandom_range(1, 64)) << $urandom_range(0, 6);
          for (int j = 0; j < h; j++) begin
            for (int i = 0; i < w; i++) begin
              send_point(x0 + 16'(i) * sx, y0 + 16'(j) * sy, (i == w - 1) && (j == h - 1));
            end
          end
          sent += w * h;
        end else begin
          if ($urandom_range(0, 1)) begin
            send_point(16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0);
          end else begin
            send_point(cx + signed_offset(), cy + signed_offset(), $urandom_range(0, 7) == 0);
          end
          sent++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
